[design/tcw_pkg.sv]
package tcw_pkg;

   localparam int COLUMNS_DEFAULT  = 80;
   localparam int ROWS_DEFAULT     = 25;
   localparam int TAB_STOP_DEFAULT = 8;

   localparam int KIND_W  = 2;
   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 11;
   localparam int POS_W   = 11;
   localparam int CELL_W  = 16;
   localparam int ATTR_W  = 8;

   localparam logic [KIND_W-1:0] KIND_CHAR  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] CODE_BACKSPACE  = 8'h08;
   localparam logic [CHAR_W-1:0] CODE_TAB        = 8'h09;
   localparam logic [CHAR_W-1:0] CODE_LF         = 8'h0A;
   localparam logic [CHAR_W-1:0] CODE_CR         = 8'h0D;
   localparam logic [CHAR_W-1:0] CODE_UP         = 8'h48;
   localparam logic [CHAR_W-1:0] CODE_LEFT       = 8'h4B;
   localparam logic [CHAR_W-1:0] CODE_RIGHT      = 8'h4D;
   localparam logic [CHAR_W-1:0] CODE_DOWN       = 8'h50;
   localparam logic [CHAR_W-1:0] CHAR_BLANK      = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PRINT_HIGH = 8'h7F;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0F;

   typedef struct packed {
      logic load_item;
      logic ptr_clear;
      logic ptr_inc;
      logic fill_wr;
      logic fill_init;
      logic copy_rd;
      logic apply_char;
      logic cursor_home;
      logic cell_rd;
      logic load_rsp;
   } tcw_cmd_type;

   typedef struct packed {
      logic need_scroll;
      logic ptr_at_copy_end;
      logic ptr_at_last;
   } tcw_status_type;

endpackage

[design/text_console_writer.sv]
// channel   direction  handshake               payload
// req       in         req_valid / req_stall   req_kind, req_char_code, req_cell_index
// rsp       out        rsp_valid / rsp_stall   rsp_cursor_position, rsp_cell_value
// csr       in         csr_write_enable        csr_write_data (attribute)
//
// one item at a time: a clear rewrites all ROWS*COLUMNS cells; a character that
// scrolls copies rows up and blanks the last row, walking the dual-port cell memory
// after reset a clearing pass over all ROWS*COLUMNS cells holds req_stall high
// a finished result waits in the output register; the next item is taken meanwhile
// and its result waits for the output register to empty while rsp_stall is high
module text_console_writer import tcw_pkg::*; #(
   parameter int COLUMNS  = COLUMNS_DEFAULT,
   parameter int ROWS     = ROWS_DEFAULT,
   parameter int TAB_STOP = TAB_STOP_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [CHAR_W-1:0]  req_char_code,
   input  logic [INDEX_W-1:0] req_cell_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [POS_W-1:0]   rsp_cursor_position,
   output logic [CELL_W-1:0]  rsp_cell_value,
   input  logic               csr_write_enable,
   input  logic [ATTR_W-1:0]  csr_write_data
);

   tcw_cmd_type    cmd;
   tcw_status_type status;

   tcw_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tcw_datapath #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_kind            (req_kind),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cell_value      (rsp_cell_value)
   );

endmodule

[design/tcw_ram.sv]
module tcw_ram import tcw_pkg::*; #(
   parameter int WIDTH = CELL_W,
   parameter int DEPTH = COLUMNS_DEFAULT * ROWS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tcw_controller.sv]
module tcw_controller import tcw_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [KIND_W-1:0]   req_kind,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  tcw_status_type      status,
   output tcw_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_CHAR,
      ST_COPY,
      ST_FLUSH,
      ST_FILL,
      ST_READ,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.fill_wr   = 1'b1;
            cmd.fill_init = 1'b1;
            cmd.ptr_inc   = 1'b1;
            if (status.ptr_at_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               cmd.ptr_clear = 1'b1;
               unique case (req_kind)
                  KIND_CHAR: begin
                     state_in = ST_CHAR;
                  end
                  KIND_CLEAR: begin
                     cmd.cursor_home = 1'b1;
                     state_in        = ST_FILL;
                  end
                  KIND_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_CHAR: begin
            cmd.apply_char = 1'b1;
            state_in       = status.need_scroll ? ST_COPY : ST_DONE;
         end
         ST_COPY: begin
            cmd.copy_rd = 1'b1;
            cmd.ptr_inc = 1'b1;
            if (status.ptr_at_copy_end) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            state_in = ST_FILL;
         end
         ST_FILL: begin
            cmd.fill_wr = 1'b1;
            cmd.ptr_inc = 1'b1;
            if (status.ptr_at_last) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            cmd.cell_rd = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while another is in progress");

   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside completion");

   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> !(rsp_valid_ff && rsp_stall))
      else $error("pending result overwritten");
`endif

endmodule

[design/tcw_datapath.sv]
module tcw_datapath import tcw_pkg::*; #(
   parameter int COLUMNS  = COLUMNS_DEFAULT,
   parameter int ROWS     = ROWS_DEFAULT,
   parameter int TAB_STOP = TAB_STOP_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  tcw_cmd_type         cmd,
   output tcw_status_type      status,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [CHAR_W-1:0]   req_char_code,
   input  logic [INDEX_W-1:0]  req_cell_index,
   input  logic                csr_write_enable,
   input  logic [ATTR_W-1:0]   csr_write_data,
   output logic [POS_W-1:0]    rsp_cursor_position,
   output logic [CELL_W-1:0]   rsp_cell_value
);

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int COPY_END   = (ROWS - 1) * COLUMNS;
   localparam int AW         = $clog2(CELL_COUNT);
   localparam int CW         = $clog2(COLUMNS);
   localparam int CX         = $clog2(COLUMNS + TAB_STOP);
   localparam int RW         = $clog2(ROWS);
   localparam int RX         = $clog2(ROWS + 1);
   localparam int PW         = $clog2(TAB_STOP);

   localparam logic [CELL_W-1:0] CELL_RESET = {ATTR_RESET, CHAR_BLANK};

   logic [CW-1:0]      col_ff, col_in;
   logic [RW-1:0]      row_ff, row_in;
   logic [PW-1:0]      phase_ff, phase_in;
   logic [AW-1:0]      ptr_ff, ptr_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [AW-1:0]      pend_addr_ff, pend_addr_in;
   logic [ATTR_W-1:0]  attr_ff, attr_in;

   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [CHAR_W-1:0]  code_ff, code_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [CELL_W-1:0]  value_ff, value_in;

   logic [CX-1:0]      col_nx;
   logic [RX-1:0]      row_nx;
   logic [PW-1:0]      phase_nx;
   logic               char_wr;
   logic [CW-1:0]      wr_col;
   logic [CHAR_W-1:0]  wr_char;
   logic               need_scroll;

   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [CELL_W-1:0]  ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [CELL_W-1:0]  ram_rd_data;

   logic [AW-1:0]      char_addr;
   logic [AW-1:0]      pos_addr;
   logic               index_in_range;
   logic [CELL_W-1:0]  fill_value;

   function automatic logic [PW-1:0] phase_up(input logic [PW-1:0] p);
      return (p == PW'(TAB_STOP - 1)) ? '0 : p + PW'(1);
   endfunction

   function automatic logic [PW-1:0] phase_down(input logic [PW-1:0] p);
      return (p == '0) ? PW'(TAB_STOP - 1) : p - PW'(1);
   endfunction

   always_comb begin
      col_nx      = CX'(col_ff);
      row_nx      = RX'(row_ff);
      phase_nx    = phase_ff;
      char_wr     = 1'b0;
      wr_col      = col_ff;
      wr_char     = code_ff;
      need_scroll = 1'b0;
      unique case (code_ff)
         CODE_BACKSPACE: begin
            if (col_ff != '0) begin
               col_nx   = CX'(col_ff) - CX'(1);
               phase_nx = phase_down(phase_ff);
               char_wr  = 1'b1;
               wr_col   = col_ff - CW'(1);
               wr_char  = CHAR_BLANK;
            end
         end
         CODE_TAB: begin
            col_nx   = CX'(col_ff) + CX'(TAB_STOP) - CX'(phase_ff);
            phase_nx = '0;
         end
         CODE_LEFT: begin
            if (col_ff != '0) begin
               col_nx   = CX'(col_ff) - CX'(1);
               phase_nx = phase_down(phase_ff);
            end
         end
         CODE_UP: begin
            if (row_ff != '0) begin
               row_nx = RX'(row_ff) - RX'(1);
            end
         end
         CODE_DOWN: begin
            row_nx = RX'(row_ff) + RX'(1);
         end
         CODE_RIGHT: begin
            col_nx   = CX'(col_ff) + CX'(1);
            phase_nx = phase_up(phase_ff);
         end
         CODE_CR: begin
            col_nx   = '0;
            phase_nx = '0;
         end
         CODE_LF: begin
            col_nx   = '0;
            phase_nx = '0;
            row_nx   = RX'(row_ff) + RX'(1);
         end
         default: begin
            if (code_ff >= CHAR_BLANK && code_ff <= CHAR_PRINT_HIGH) begin
               char_wr  = 1'b1;
               col_nx   = CX'(col_ff) + CX'(1);
               phase_nx = phase_up(phase_ff);
            end
         end
      endcase
      if (col_nx >= CX'(COLUMNS)) begin
         col_nx   = '0;
         phase_nx = '0;
         row_nx   = row_nx + RX'(1);
      end
      if (row_nx >= RX'(ROWS)) begin
         row_nx      = RX'(ROWS - 1);
         need_scroll = 1'b1;
      end
   end

   assign char_addr      = AW'(row_ff) * AW'(COLUMNS) + AW'(wr_col);
   assign pos_addr       = AW'(row_ff) * AW'(COLUMNS) + AW'(col_ff);
   assign index_in_range = (32'(index_ff) < 32'(CELL_COUNT));
   assign fill_value     = cmd.fill_init ? CELL_RESET : {attr_ff, CHAR_BLANK};

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_addr = ptr_ff;
      ram_wr_data = fill_value;
      if (pend_valid_ff) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = pend_addr_ff;
         ram_wr_data = ram_rd_data;
      end else if (cmd.fill_wr) begin
         ram_wr_en = 1'b1;
      end else if (cmd.apply_char && char_wr) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = char_addr;
         ram_wr_data = {attr_ff, wr_char};
      end
   end

   assign ram_rd_en   = cmd.copy_rd | cmd.cell_rd;
   assign ram_rd_addr = cmd.copy_rd ? (ptr_ff + AW'(COLUMNS)) : AW'(index_ff);

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cells (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      col_in   = col_ff;
      row_in   = row_ff;
      phase_in = phase_ff;
      if (cmd.cursor_home) begin
         col_in   = '0;
         row_in   = '0;
         phase_in = '0;
      end else if (cmd.apply_char) begin
         col_in   = CW'(col_nx);
         row_in   = RW'(row_nx);
         phase_in = phase_nx;
      end
   end

   assign ptr_in        = cmd.ptr_clear ? '0 : (cmd.ptr_inc ? ptr_ff + AW'(1) : ptr_ff);
   assign pend_valid_in = cmd.copy_rd;
   assign pend_addr_in  = ptr_ff;
   assign attr_in       = csr_write_enable ? csr_write_data : attr_ff;

   assign kind_in  = cmd.load_item ? req_kind : kind_ff;
   assign code_in  = cmd.load_item ? req_char_code : code_ff;
   assign index_in = cmd.load_item ? req_cell_index : index_ff;
   assign pos_in   = cmd.load_rsp ? POS_W'(pos_addr) : pos_ff;
   assign value_in = cmd.load_rsp ?
                     ((kind_ff == KIND_READ && index_in_range) ? ram_rd_data : '0) :
                     value_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff        <= '0;
         row_ff        <= '0;
         phase_ff      <= '0;
         ptr_ff        <= '0;
         pend_valid_ff <= 1'b0;
         attr_ff       <= ATTR_RESET;
      end else begin
         col_ff        <= col_in;
         row_ff        <= row_in;
         phase_ff      <= phase_in;
         ptr_ff        <= ptr_in;
         pend_valid_ff <= pend_valid_in;
         attr_ff       <= attr_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      kind_ff      <= kind_in;
      code_ff      <= code_in;
      index_ff     <= index_in;
      pos_ff       <= pos_in;
      value_ff     <= value_in;
   end

   assign status.need_scroll     = need_scroll;
   assign status.ptr_at_copy_end = (ptr_ff == AW'(COPY_END - 1));
   assign status.ptr_at_last     = (ptr_ff == AW'(CELL_COUNT - 1));

   assign rsp_cursor_position = pos_ff;
   assign rsp_cell_value      = value_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (32'(col_ff) < 32'(COLUMNS)) && (32'(row_ff) < 32'(ROWS)))
      else $error("cursor outside screen");

   assert property (@(posedge clock) disable iff (reset)
      !(pend_valid_ff && (cmd.fill_wr || cmd.apply_char)))
      else $error("scroll copy write collides with another write");

   assert property (@(posedge clock) disable iff (reset)
      cmd.cursor_home |=> (col_ff == '0 && row_ff == '0 && phase_ff == '0))
      else $error("cursor not home after clear");
`endif

endmodule

[test/text_console_writer_check.sv]
`timescale 1ns / 1ps

module text_console_writer_check import tcw_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [KIND_W-1:0]  req_kind,
   input  logic [CHAR_W-1:0]  req_char_code,
   input  logic [INDEX_W-1:0] req_cell_index,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [POS_W-1:0]   rsp_cursor_position,
   input  logic [CELL_W-1:0]  rsp_cell_value,
   input  logic               csr_write_enable,
   input  logic [ATTR_W-1:0]  csr_write_data,
   output int                 mismatch_count,
   output int                 pending_count,
   output int                 results_compared,
   output int                 scroll_count,
   output int                 clear_count
);

   localparam int COLS  = COLUMNS_DEFAULT;
   localparam int LINES = ROWS_DEFAULT;
   localparam int TAB   = TAB_STOP_DEFAULT;
   localparam int CELLS = COLS * LINES;

   typedef struct packed {
      logic [POS_W-1:0]  cursor;
      logic [CELL_W-1:0] cell_value;
   } console_rsp_type;

   logic [CELL_W-1:0] screen [CELLS];
   int                cur_col;
   int                cur_row;
   logic [ATTR_W-1:0] attr_reg;
   console_rsp_type   expected_rsp_q [$];

   initial begin
      mismatch_count   = 0;
      pending_count    = 0;
      results_compared = 0;
      scroll_count     = 0;
      clear_count      = 0;
   end

   function automatic void console_home(input logic [ATTR_W-1:0] attr);
      int i;
      for (i = 0; i < CELLS; i++) screen[i] = {attr, CHAR_BLANK};
      cur_col = 0;
      cur_row = 0;
   endfunction

   function automatic console_rsp_type console_apply(input logic [KIND_W-1:0] kind,
                                                     input logic [CHAR_W-1:0] code,
                                                     input logic [INDEX_W-1:0] index);
      console_rsp_type r;
      int              i;
      r.cell_value = '0;
      case (kind)
         KIND_CHAR: begin
            if (code == CODE_BACKSPACE) begin
               if (cur_col != 0) begin
                  cur_col--;
                  screen[cur_row * COLS + cur_col] = {attr_reg, CHAR_BLANK};
               end
            end else if (code == CODE_TAB) begin
               cur_col = cur_col + TAB - (cur_col % TAB);
            end else if (code == CODE_LEFT) begin
               if (cur_col != 0) cur_col--;
            end else if (code == CODE_UP) begin
               if (cur_row != 0) cur_row--;
            end else if (code == CODE_DOWN) begin
               cur_row++;
            end else if (code == CODE_RIGHT) begin
               cur_col++;
            end else if (code == CODE_CR) begin
               cur_col = 0;
            end else if (code == CODE_LF) begin
               cur_col = 0;
               cur_row++;
            end else if (code >= CHAR_BLANK && code <= CHAR_PRINT_HIGH) begin
               screen[cur_row * COLS + cur_col] = {attr_reg, code};
               cur_col++;
            end
            if (cur_col >= COLS) begin
               cur_col = 0;
               cur_row++;
            end
            // past the last row: shift everything up one row
            if (cur_row >= LINES) begin
               for (i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
               for (i = CELLS - COLS; i < CELLS; i++) screen[i] = {attr_reg, CHAR_BLANK};
               cur_row = LINES - 1;
               scroll_count++;
            end
         end
         KIND_CLEAR: begin
            console_home(attr_reg);
            clear_count++;
         end
         KIND_READ: begin
            if (int'(index) < CELLS) r.cell_value = screen[index];
         end
         default: ;
      endcase
      r.cursor = POS_W'(cur_row * COLS + cur_col);
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      console_rsp_type exp_rsp;
      if (reset) begin
         attr_reg = ATTR_RESET;
         console_home(ATTR_RESET);
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: unexpected result cursor_position %0d cell_value %h",
                           $realtime, rsp_cursor_position, rsp_cell_value);
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               results_compared++;
               if (rsp_cursor_position !== exp_rsp.cursor
                   || rsp_cell_value !== exp_rsp.cell_value) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"%0t: mismatch cursor_position exp %0d got %0d, ",
                               "cell_value exp %h got %h"},
                              $realtime, exp_rsp.cursor, rsp_cursor_position,
                              exp_rsp.cell_value, rsp_cell_value);
               end
            end
         end
         if (csr_write_enable) attr_reg = csr_write_data;
         if (req_valid && !req_stall)
            expected_rsp_q.push_back(console_apply(req_kind, req_char_code, req_cell_index));
      end
      pending_count = expected_rsp_q.size();
   end

endmodule

[test/text_console_writer_test.sv]
`timescale 1ns / 1ps

module text_console_writer_test;
   import tcw_pkg::*;

   localparam int                CYCLE_LIMIT = 8_000_000;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic               clock            = 1'b0;
   logic               reset            = 1'b1;
   logic               req_valid        = 1'b0;
   logic [KIND_W-1:0]  req_kind         = KIND_CHAR;
   logic [CHAR_W-1:0]  req_char_code    = '0;
   logic [INDEX_W-1:0] req_cell_index   = '0;
   logic               rsp_stall        = 1'b0;
   logic               csr_write_enable = 1'b0;
   logic [ATTR_W-1:0]  csr_write_data   = '0;
   logic               req_stall;
   logic               rsp_valid;
   logic [POS_W-1:0]   rsp_cursor_position;
   logic [CELL_W-1:0]  rsp_cell_value;

   int mismatch_count;
   int pending_count;
   int results_compared;
   int scroll_count;
   int clear_count;
   int items_sent   = 0;
   int req_idle_pct = 23;
   int rsp_idle_pct = 79;
   int cycle_count  = 0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   text_console_writer uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cell_value      (rsp_cell_value),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   text_console_writer_check console_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_char_code       (req_char_code),
      .req_cell_index      (req_cell_index),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_cursor_position (rsp_cursor_position),
      .rsp_cell_value      (rsp_cell_value),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .mismatch_count      (mismatch_count),
      .pending_count       (pending_count),
      .results_compared    (results_compared),
      .scroll_count        (scroll_count),
      .clear_count         (clear_count)
   );

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_idle_pct);
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Some tests failed");
      $finish;
   end

   // called at a falling edge; leaves valid high after the item is taken
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] code,
                            input logic [INDEX_W-1:0] index);
      if ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(0, 99) < req_idle_pct) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_char_code  <= code;
      req_cell_index <= index;
      do @(posedge clock); while (req_stall);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_attribute(input logic [ATTR_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_random_item();
      int                 pick;
      int                 sub;
      logic [KIND_W-1:0]  kind;
      logic [CHAR_W-1:0]  code;
      logic [INDEX_W-1:0] index;
      pick  = $urandom_range(0, 999);
      kind  = KIND_CHAR;
      code  = CHAR_W'($urandom_range(0, 255));
      index = INDEX_W'($urandom_range(0, 2047));
      if (pick < 600) begin
         code = CHAR_W'($urandom_range(CHAR_BLANK, CHAR_PRINT_HIGH));
      end else if (pick < 680) begin
         code = CODE_LF;
      end else if (pick < 780) begin
         case ($urandom_range(0, 7))
            0: code = CODE_BACKSPACE;
            1: code = CODE_TAB;
            2: code = CODE_CR;
            3: code = CODE_LF;
            4: code = CODE_LEFT;
            5: code = CODE_UP;
            6: code = CODE_DOWN;
            default: code = CODE_RIGHT;
         endcase
      end else if (pick < 820) begin
         kind = KIND_CHAR;
      end else if (pick < 980) begin
         kind = KIND_READ;
         sub  = $urandom_range(0, 9);
         if (sub < 5) index = INDEX_W'($urandom_range(0, 1999));
         else if (sub < 9) index = INDEX_W'($urandom_range(1600, 1999));
         else index = INDEX_W'($urandom_range(2000, 2047));
      end else if (pick < 983) begin
         kind = KIND_CLEAR;
      end else begin
         kind = KIND_UNUSED;
      end
      send_item(kind, code, index);
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input int count);
      req_idle_pct = send_pct;
      rsp_idle_pct = recv_pct;
      repeat (count) begin
         if ($urandom_range(0, 149) == 0) drain();
         send_random_item();
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset contents, reads past the end, unused kind
      send_item(KIND_READ, 8'h00, 11'd0);
      send_item(KIND_READ, 8'hFF, 11'd1999);
      send_item(KIND_READ, 8'h00, 11'd2000);
      send_item(KIND_READ, 8'h00, 11'd2047);
      send_item(KIND_UNUSED, 8'hFF, 11'd2047);
      // printable range edges and ignored bytes
      send_item(KIND_CHAR, 8'h41, 11'd0);
      send_item(KIND_CHAR, CHAR_PRINT_HIGH, 11'd0);
      send_item(KIND_CHAR, CHAR_BLANK, 11'd0);
      send_item(KIND_CHAR, 8'h80, 11'd0);
      send_item(KIND_CHAR, 8'hFF, 11'd0);
      send_item(KIND_CHAR, 8'h00, 11'd0);
      // control codes and arrows, saturation at the top and left edges
      send_item(KIND_CHAR, CODE_TAB, 11'd0);
      send_item(KIND_CHAR, CODE_BACKSPACE, 11'd0);
      send_item(KIND_CHAR, CODE_LEFT, 11'd0);
      send_item(KIND_CHAR, CODE_RIGHT, 11'd0);
      send_item(KIND_CHAR, CODE_UP, 11'd0);
      send_item(KIND_CHAR, CODE_DOWN, 11'd0);
      send_item(KIND_CHAR, CODE_CR, 11'd0);
      send_item(KIND_CHAR, CODE_LF, 11'd0);
      send_item(KIND_CHAR, CODE_BACKSPACE, 11'd0);
      send_item(KIND_CHAR, CODE_LEFT, 11'd0);
      send_item(KIND_READ, 8'h00, 11'd0);
      drain();

      write_attribute(8'h00);
      send_item(KIND_CLEAR, 8'h00, 11'd0);
      send_item(KIND_READ, 8'h00, 11'd5);
      drain();

      write_attribute(8'hFF);
      run_phase(23, 79, 370);
      drain();

      write_attribute(ATTR_W'($urandom_range(1, 254)));
      run_phase(79, 23, 370);
      drain();

      write_attribute(ATTR_W'($urandom_range(0, 255)));
      run_phase(0, 0, 370);
      drain();

      repeat (2100) @(negedge clock);

      $display("sent %0d items under three idle patterns and attributes 0x0F, 0x00, 0xFF, random",
               items_sent);
      $display("compared %0d results; %0d scrolls and %0d clears predicted",
               results_compared, scroll_count, clear_count);
      if (pending_count != 0)
         $display("%0d expected results never arrived", pending_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
